FILE: rtl/hptc_pkg.sv
package hptc_pkg;

  localparam int unsigned TABLE_SEGMENTS_DEF = 1024;

  localparam int unsigned DATA_W   = 24;
  localparam int unsigned GAIN_W   = 20;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned SCALED_W = 44;
  localparam int unsigned SHAPED_W = 44;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned LANES    = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd131081;

  // Shaper breakpoints and coefficients, Q.32 thresholds and Q.16 factors
  localparam logic signed [SCALED_W-1:0] TOE_START  = 44'sd10737418;
  localparam logic signed [SCALED_W-1:0] LIN_OFFSET = 44'sd21474836;
  localparam logic signed [SCALED_W-1:0] LIN_START  = 44'sd32212255;
  localparam logic [22:0] TOE_COEF  = 23'd6586533;
  localparam logic [16:0] LIN_SLOPE = 17'd65865;

  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_PIXEL       = 1'b1;

  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } tbl_wr_t;

  // Everything the midpoint path needs besides the divider operands
  typedef struct packed {
    logic signed [DATA_W-1:0] ly;
    logic signed [DATA_W-1:0] hy;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    logic [1:0]               mid;
    logic                     eq;
    logic                     early;
  } mid_info_t;

endpackage

FILE: rtl/hptc_lane.sv
module hptc_lane #(
  parameter int unsigned TABLE_SEGMENTS = hptc_pkg::TABLE_SEGMENTS_DEF
) (
  input  logic                                  clk_i,
  input  logic [6:0]                            ld_i,
  input  logic [hptc_pkg::GAIN_W-1:0]           gain_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]    sample_i,
  input  hptc_pkg::tbl_wr_t                     wr_i,
  output logic signed [hptc_pkg::DATA_W-1:0]    y_o,
  output logic [hptc_pkg::SHAPED_W-1:0]         shaped_o
);

  localparam int unsigned AW      = $clog2(TABLE_SEGMENTS + 1);
  localparam int unsigned POS_W   = hptc_pkg::SHAPED_W + AW;
  localparam int unsigned IP_W    = POS_W - hptc_pkg::FRAC_W;
  localparam int unsigned DW_W    = hptc_pkg::DATA_W + 1 + IP_W + 1;
  localparam int unsigned DP_W    = hptc_pkg::DATA_W + 1 + hptc_pkg::FRAC_W + 1;
  localparam int unsigned Y_W     = DW_W + 2;
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(8388607);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - 1;

  typedef enum logic [1:0] {
    SHP_ZERO = 2'd0,
    SHP_TOE  = 2'd1,
    SHP_LIN  = 2'd2
  } shape_sel_e;

  // stage 0: exposure
  logic signed [44:0]                   prod0;
  logic signed [hptc_pkg::SCALED_W-1:0] s_q;

  assign prod0 = sample_i * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) s_q <= prod0[hptc_pkg::SCALED_W-1:0];
  end

  // stage 1: segment select and first products
  logic [hptc_pkg::SCALED_W-1:0] lin_d;
  logic [24:0]                   toe_d;
  logic [60:0]                   lin_prod, lin_q;
  logic [49:0]                   dd, dd_q;
  shape_sel_e                    sel_d, sel1_q, sel2_q;

  always_comb begin
    lin_d    = hptc_pkg::SCALED_W'(s_q - hptc_pkg::LIN_OFFSET);
    toe_d    = 25'(s_q - hptc_pkg::TOE_START);
    lin_prod = 61'(lin_d) * 61'(hptc_pkg::LIN_SLOPE);
    dd       = 50'(toe_d) * 50'(toe_d);
    if (s_q >= hptc_pkg::LIN_START) sel_d = SHP_LIN;
    else if (s_q <= hptc_pkg::TOE_START) sel_d = SHP_ZERO;
    else sel_d = SHP_TOE;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      lin_q  <= lin_prod;
      dd_q   <= dd;
      sel1_q <= sel_d;
    end
  end

  // stage 2: toe coefficient
  logic [56:0]                   toe_prod, toe_q;
  logic [hptc_pkg::SHAPED_W-1:0] lin_sh_q;

  assign toe_prod = 57'(dd_q[49:16]) * 57'(hptc_pkg::TOE_COEF);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      toe_q    <= toe_prod;
      lin_sh_q <= lin_q[59:16];
      sel2_q   <= sel1_q;
    end
  end

  // stage 3: shaped value
  logic [hptc_pkg::SHAPED_W-1:0] shaped_d, sh3_q;

  always_comb begin
    case (sel2_q)
      SHP_LIN: shaped_d = lin_sh_q;
      SHP_TOE: shaped_d = hptc_pkg::SHAPED_W'(toe_q[56:32]);
      default: shaped_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) sh3_q <= shaped_d;
  end

  // stage 4: table position and read
  logic [POS_W-1:0]               pos;
  logic [IP_W-1:0]                ip, whole_d, whole_q;
  logic [AW-1:0]                  idx, idx1;
  logic [hptc_pkg::FRAC_W-1:0]    part_q;
  logic [hptc_pkg::SHAPED_W-1:0]  sh4_q, sh5_q, sh6_q;
  logic signed [hptc_pkg::DATA_W-1:0] mem [0:TABLE_SEGMENTS];
  logic signed [hptc_pkg::DATA_W-1:0] lo_q, hi_q, lo5_q;

  always_comb begin
    pos = POS_W'(sh3_q) * POS_W'(TABLE_SEGMENTS);
    ip  = pos[POS_W-1:hptc_pkg::FRAC_W];
    if (ip > IP_W'(TABLE_SEGMENTS - 1)) begin
      idx     = AW'(TABLE_SEGMENTS - 1);
      whole_d = ip - IP_W'(TABLE_SEGMENTS - 1);
    end else begin
      idx     = AW'(ip);
      whole_d = '0;
    end
    idx1 = idx + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[AW'(wr_i.index)] <= wr_i.value;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      lo_q    <= mem[idx];
      hi_q    <= mem[idx1];
      whole_q <= whole_d;
      part_q  <= pos[hptc_pkg::FRAC_W-1:0];
      sh4_q   <= sh3_q;
    end
  end

  // stage 5: interpolation products
  logic signed [hptc_pkg::DATA_W:0] delta;
  logic signed [DW_W-1:0]           dw, dw_q;
  logic signed [DP_W-1:0]           dp, dp_q;

  always_comb begin
    delta = {hi_q[hptc_pkg::DATA_W-1], hi_q} - {lo_q[hptc_pkg::DATA_W-1], lo_q};
    dw    = delta * $signed({1'b0, whole_q});
    dp    = delta * $signed({1'b0, part_q});
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      dw_q  <= dw;
      dp_q  <= dp;
      lo5_q <= lo_q;
      sh5_q <= sh4_q;
    end
  end

  // stage 6: sum and saturate
  logic signed [Y_W-1:0]               sum;
  logic signed [hptc_pkg::DATA_W-1:0]  y_d, y_q;

  always_comb begin
    sum = Y_W'(lo5_q) + Y_W'(dw_q)
        + Y_W'($signed(dp_q[DP_W-1:hptc_pkg::FRAC_W]));
    if (sum > Y_MAX) y_d = 24'sh7fffff;
    else if (sum < Y_MIN) y_d = 24'sh800000;
    else y_d = sum[hptc_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      y_q   <= y_d;
      sh6_q <= sh5_q;
    end
  end

  assign y_o      = y_q;
  assign shaped_o = sh6_q;

endmodule

FILE: rtl/hptc_div.sv
module hptc_div (
  input  logic                              clk_i,
  input  logic [hptc_pkg::DIV_W-1:0]        ld_i,
  input  logic [hptc_pkg::SHAPED_W-1:0]     den_i,
  input  logic [hptc_pkg::SHAPED_W-1:0]     rem_i,
  input  hptc_pkg::mid_info_t               info_i,
  output logic [hptc_pkg::DIV_W-1:0]        q_o,
  output hptc_pkg::mid_info_t               info_o
);

  localparam int unsigned N  = hptc_pkg::DIV_W;
  localparam int unsigned RW = hptc_pkg::SHAPED_W;

  logic [RW-1:0]       rem_q  [0:N-1];
  logic [RW-1:0]       den_q  [0:N-1];
  logic [N-1:0]        q_q    [0:N-1];
  hptc_pkg::mid_info_t info_q [0:N-1];

  logic [RW-1:0]       rem_in [0:N-1];
  logic [RW-1:0]       den_in [0:N-1];
  logic [N-1:0]        q_in   [0:N-1];
  hptc_pkg::mid_info_t inf_in [0:N-1];
  logic [RW:0]         r2     [0:N-1];
  logic                take   [0:N-1];

  // one quotient bit per stage, restoring
  always_comb begin
    rem_in[0] = rem_i;
    den_in[0] = den_i;
    q_in[0]   = '0;
    inf_in[0] = info_i;
    for (int k = 1; k < N; k++) begin
      rem_in[k] = rem_q[k-1];
      den_in[k] = den_q[k-1];
      q_in[k]   = q_q[k-1];
      inf_in[k] = info_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      r2[k]   = {rem_in[k], 1'b0};
      take[k] = r2[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (ld_i[k]) begin
        rem_q[k]  <= take[k] ? RW'(r2[k] - {1'b0, den_in[k]}) : r2[k][RW-1:0];
        q_q[k]    <= {q_in[k][N-2:0], take[k]};
        den_q[k]  <= den_in[k];
        info_q[k] <= inf_in[k];
      end
    end
  end

  assign q_o    = q_q[N-1];
  assign info_o = info_q[N-1];

endmodule

FILE: rtl/hue_preserving_tone_curve.sv
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  command, RGBA samples, table index and value
// out      out_valid_o/out_ready_i RGBA tone-mapped
// cfg      cfg_we_i               exposure gain, written at once
//
// One beat per clock sustained while out_ready_i is high.
// Seven stages per lane (exposure, shaper, table read, interpolation), a sort
// stage, a 32-stage quotient pipeline for the middle channel, multiply, output.
// A table write travels to the table read stage and is written there, so it
// stays ordered with pixels around it; it yields no output beat.
// Each stage moves up when it is empty or the next one moves; input stalls only
// when every stage holds a beat. Reset clears valids and restores the gain; the
// table holds nothing defined until written.
module hue_preserving_tone_curve #(
  parameter int unsigned TABLE_SEGMENTS = hptc_pkg::TABLE_SEGMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hptc_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]   red_in_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]   green_in_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]   blue_in_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]   alpha_in_i,
  input  logic [hptc_pkg::IDX_W-1:0]           table_index_i,
  input  logic signed [hptc_pkg::DATA_W-1:0]   table_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [hptc_pkg::DATA_W-1:0]   red_out_o,
  output logic signed [hptc_pkg::DATA_W-1:0]   green_out_o,
  output logic signed [hptc_pkg::DATA_W-1:0]   blue_out_o,
  output logic signed [hptc_pkg::DATA_W-1:0]   alpha_out_o
);

  localparam int unsigned NST    = 42;
  localparam int unsigned ST_SRT = 7;
  localparam int unsigned ST_DIV = 8;
  localparam int unsigned ST_MUL = ST_DIV + hptc_pkg::DIV_W;
  localparam int unsigned ST_OUT = ST_MUL + 1;
  localparam int unsigned DW     = hptc_pkg::DATA_W;
  localparam int unsigned XW     = hptc_pkg::SHAPED_W;

  logic [hptc_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= hptc_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // stage advance chain
  logic [NST-1:0] v_q, v_in;
  logic [NST:0]   ld;

  logic                            cmd_q  [0:3];
  logic [hptc_pkg::IDX_W-1:0]      tidx_q [0:3];
  logic signed [DW-1:0]            tval_q [0:3];
  logic signed [DW-1:0]            alpha_q [0:NST-1];

  always_comb begin
    ld[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) ld[k] = !v_q[k] | ld[k+1];
    v_in[0] = in_valid_i;
    for (int k = 1; k < NST; k++) v_in[k] = v_q[k-1];
    // drop table writes once they reach the table
    v_in[4] = v_q[3] & (cmd_q[3] == hptc_pkg::CMD_PIXEL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (ld[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign in_ready_o = ld[0];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      cmd_q[0]   <= command_i;
      tidx_q[0]  <= table_index_i;
      tval_q[0]  <= table_value_i;
      alpha_q[0] <= alpha_in_i;
    end
    for (int k = 1; k < 4; k++) begin
      if (ld[k]) begin
        cmd_q[k]  <= cmd_q[k-1];
        tidx_q[k] <= tidx_q[k-1];
        tval_q[k] <= tval_q[k-1];
      end
    end
    for (int k = 1; k < NST; k++) begin
      if (ld[k]) alpha_q[k] <= alpha_q[k-1];
    end
  end

  hptc_pkg::tbl_wr_t wr;

  always_comb begin
    wr.en    = ld[4] & v_q[3] & (cmd_q[3] == hptc_pkg::CMD_TABLE_WRITE)
             & (32'(tidx_q[3]) <= TABLE_SEGMENTS);
    wr.index = tidx_q[3];
    wr.value = tval_q[3];
  end

  // lanes
  logic signed [DW-1:0] sample [0:hptc_pkg::LANES-1];
  logic signed [DW-1:0] ly_l   [0:hptc_pkg::LANES-1];
  logic [XW-1:0]        x_l    [0:hptc_pkg::LANES-1];

  assign sample[0] = red_in_i;
  assign sample[1] = green_in_i;
  assign sample[2] = blue_in_i;

  for (genvar c = 0; c < hptc_pkg::LANES; c++) begin : g_lane
    hptc_lane #(
      .TABLE_SEGMENTS(TABLE_SEGMENTS)
    ) u_lane (
      .clk_i   (clk_i),
      .ld_i    (ld[6:0]),
      .gain_i  (gain_q),
      .sample_i(sample[c]),
      .wr_i    (wr),
      .y_o     (ly_l[c]),
      .shaped_o(x_l[c])
    );
  end

  // merge: stable sort of the three shaped values
  logic [1:0]           min_i, max_i, mid_i;
  logic [XW-1:0]        xl, xm, xh;
  logic signed [DW-1:0] yl, yh;
  hptc_pkg::mid_info_t  info_d, info7_q, info_div, info40_q;
  logic [XW-1:0]        den_q, rem_q;

  always_comb begin
    if (x_l[0] <= x_l[1] && x_l[0] <= x_l[2]) min_i = 2'd0;
    else if (x_l[1] <= x_l[2]) min_i = 2'd1;
    else min_i = 2'd2;
    if (x_l[2] >= x_l[0] && x_l[2] >= x_l[1]) max_i = 2'd2;
    else if (x_l[1] >= x_l[0]) max_i = 2'd1;
    else max_i = 2'd0;
    mid_i = 2'd3 - min_i - max_i;
    case (min_i)
      2'd0:    begin xl = x_l[0]; yl = ly_l[0]; end
      2'd1:    begin xl = x_l[1]; yl = ly_l[1]; end
      default: begin xl = x_l[2]; yl = ly_l[2]; end
    endcase
    case (max_i)
      2'd0:    begin xh = x_l[0]; yh = ly_l[0]; end
      2'd1:    begin xh = x_l[1]; yh = ly_l[1]; end
      default: begin xh = x_l[2]; yh = ly_l[2]; end
    endcase
    case (mid_i)
      2'd0:    xm = x_l[0];
      2'd1:    xm = x_l[1];
      default: xm = x_l[2];
    endcase
    info_d.ly    = yl;
    info_d.hy    = yh;
    info_d.y0    = ly_l[0];
    info_d.y1    = ly_l[1];
    info_d.y2    = ly_l[2];
    info_d.mid   = mid_i;
    info_d.eq    = (xl == xh);
    info_d.early = (xm - xl) >= (xh - xl);
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_SRT]) begin
      info7_q <= info_d;
      den_q   <= xh - xl;
      rem_q   <= xm - xl;
    end
  end

  logic [hptc_pkg::DIV_W-1:0] q_div;

  hptc_div u_div (
    .clk_i (clk_i),
    .ld_i  (ld[ST_MUL-1:ST_DIV]),
    .den_i (den_q),
    .rem_i (rem_q),
    .info_i(info7_q),
    .q_o   (q_div),
    .info_o(info_div)
  );

  // midpoint product
  logic signed [DW:0]    span;
  logic signed [DW+33:0] prod, prod_q;

  always_comb begin
    span = {info_div.hy[DW-1], info_div.hy} - {info_div.ly[DW-1], info_div.ly};
    prod = $signed({1'b0, q_div}) * span;
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL]) begin
      prod_q   <= prod;
      info40_q <= info_div;
    end
  end

  // output register
  logic signed [DW+1:0] mid_sum;
  logic signed [DW-1:0] own_mid, mid_val;
  logic signed [DW-1:0] red_q, green_q, blue_q;

  always_comb begin
    mid_sum = {{2{info40_q.ly[DW-1]}}, info40_q.ly} + $signed(prod_q[DW+33:32]);
    case (info40_q.mid)
      2'd0:    own_mid = info40_q.y0;
      2'd1:    own_mid = info40_q.y1;
      default: own_mid = info40_q.y2;
    endcase
    if (info40_q.eq) mid_val = own_mid;
    else if (info40_q.early) mid_val = info40_q.hy;
    else mid_val = mid_sum[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_OUT]) begin
      red_q   <= (info40_q.mid == 2'd0) ? mid_val : info40_q.y0;
      green_q <= (info40_q.mid == 2'd1) ? mid_val : info40_q.y1;
      blue_q  <= (info40_q.mid == 2'd2) ? mid_val : info40_q.y2;
    end
  end

  assign out_valid_o = v_q[ST_OUT];
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q[ST_OUT];

`ifndef ASSERT_OFF
  a_write_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld[4] && v_q[3] && cmd_q[3] == hptc_pkg::CMD_TABLE_WRITE |=> !v_q[4])
    else $error("table write passed the table stage");

  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> in_ready_o)
    else $error("input stalled with an empty stage");

  a_eq_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_SRT] && info7_q.eq |-> info7_q.early)
    else $error("equal extremes without early exit");
`endif

endmodule
